// ===== sv/spq_pkg.sv =====
package spq_pkg;

  // Default capacity of the queue.
  localparam int DEPTH_DEF = 16;

  // Field widths.
  localparam int ID_W   = 32;
  localparam int PRIO_W = 16;
  localparam int TAG_W  = 32;
  localparam int OCC_W  = 5;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;

  // First id given out, and the value the counter wraps back to.
  localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);

  // Operation codes carried on the mode field.
  typedef enum logic [MODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the request payload
    logic compare;     // evaluate the slot comparisons
    logic apply;       // register the result fields
    logic commit_ins;  // insert the captured entry
    logic commit_rem;  // unlink the first hit entry
    op_t  op;          // operation being compared
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;  // every slot is occupied
    logic hit;   // the compare found an entry to remove
  } dp_stat_t;

endpackage

// ===== sv/spq_ctrl.sv =====
module spq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_mode,
  input  spq_pkg::dp_stat_t  stat,
  output logic               busy,
  output spq_pkg::dp_cmd_t   cmd,
  output logic               out_valid,
  output logic [1:0]         out_status
);

  spq_pkg::state_t  state_r, state_nxt;
  spq_pkg::op_t     op_r, op_nxt;
  spq_pkg::status_t status_r, status_nxt;
  logic             valid_r, valid_nxt;
  logic             accept;

  // A new request is taken in idle and also while the previous one commits.
  assign busy   = (state_r == spq_pkg::S_CMP);
  assign accept = start && !busy;

  // State, operation and result strobe registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::S_IDLE;
      op_r    <= spq_pkg::OP_NONE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Result status needs no reset; it is qualified by the strobe.
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    status_nxt     = status_r;
    valid_nxt      = 1'b0;
    cmd            = '0;
    cmd.op         = op_r;
    cmd.load       = accept;
    if (accept) begin
      op_nxt = spq_pkg::op_t'(in_mode);
    end
    case (state_r)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = spq_pkg::S_CMP;
        end
      end
      spq_pkg::S_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = spq_pkg::S_APPLY;
      end
      spq_pkg::S_APPLY: begin
        cmd.apply = 1'b1;
        valid_nxt = 1'b1;
        case (op_r)
          spq_pkg::OP_INSERT: begin
            cmd.commit_ins = !stat.full;
            status_nxt     = stat.full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
          end
          spq_pkg::OP_POP, spq_pkg::OP_REMOVE: begin
            cmd.commit_rem = stat.hit;
            status_nxt     = stat.hit ? spq_pkg::ST_OK : spq_pkg::ST_EMPTY;
          end
          default: begin
            status_nxt = spq_pkg::ST_EMPTY;
          end
        endcase
        state_nxt = accept ? spq_pkg::S_CMP : spq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid  = valid_r;
  assign out_status = status_r;

  // The compare state always hands over to the commit state.
  a_cmp_to_apply: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (state_r == spq_pkg::S_APPLY))
    else $error("compare state not followed by commit");

  // A transfer of a request always leads into the compare state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted request did not start compare");

  // The result strobe is never high in consecutive cycles.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe in consecutive cycles");

endmodule

// ===== sv/spq_datapath.sv =====
module spq_datapath #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spq_pkg::dp_cmd_t                    cmd,
  input  logic signed [spq_pkg::PRIO_W-1:0]   in_priority_req,
  input  logic [spq_pkg::TAG_W-1:0]           in_tag,
  input  logic [spq_pkg::ID_W-1:0]            in_target_id,
  output spq_pkg::dp_stat_t                   stat,
  output logic [spq_pkg::ID_W-1:0]            out_entry_id,
  output logic signed [spq_pkg::PRIO_W-1:0]   out_entry_priority,
  output logic [spq_pkg::TAG_W-1:0]           out_entry_tag,
  output logic [spq_pkg::OCC_W-1:0]           out_occupancy
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IdW   = spq_pkg::ID_W;
  localparam int PrioW = spq_pkg::PRIO_W;
  localparam int TagW  = spq_pkg::TAG_W;
  localparam int OccW  = spq_pkg::OCC_W;

  // Slot register array, head in slot 0.
  logic [IdW-1:0]          slot_id_r   [DEPTH];
  logic signed [PrioW-1:0] slot_prio_r [DEPTH];
  logic [TagW-1:0]         slot_tag_r  [DEPTH];
  logic [IdW-1:0]          slot_id_nxt   [DEPTH];
  logic signed [PrioW-1:0] slot_prio_nxt [DEPTH];
  logic [TagW-1:0]         slot_tag_nxt  [DEPTH];

  logic [CW-1:0]  count_r, count_nxt;
  logic [IdW-1:0] next_id_r, next_id_nxt;

  // Captured request payload.
  logic signed [PrioW-1:0] req_prio_r;
  logic [TagW-1:0]         req_tag_r;
  logic [IdW-1:0]          req_target_r;

  // Compare vectors: slots that stay ahead of a new entry, and removal hits.
  logic [DEPTH-1:0] ge_r, ge_nxt;
  logic [DEPTH-1:0] match_r, match_nxt;
  logic [DEPTH-1:0] first_hit;
  logic [DEPTH-1:0] at_or_after;

  logic [IdW-1:0]          sel_id;
  logic signed [PrioW-1:0] sel_prio;
  logic [TagW-1:0]         sel_tag;

  logic [IdW-1:0]          res_id_r;
  logic signed [PrioW-1:0] res_prio_r;
  logic [TagW-1:0]         res_tag_r;
  logic [OccW-1:0]         res_occ_r;

  assign stat.full = (count_r == CW'(DEPTH));
  assign stat.hit  = |match_r;

  // Per-slot comparisons against the captured request.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge_nxt[i]    = (CW'(i) < count_r) && (slot_prio_r[i] >= req_prio_r);
      match_nxt[i] = 1'b0;
      case (cmd.op)
        spq_pkg::OP_POP:    match_nxt[i] = (i == 0) && (count_r != '0);
        spq_pkg::OP_REMOVE: match_nxt[i] = (CW'(i) < count_r) &&
                                           (slot_id_r[i] == req_target_r);
        default:            match_nxt[i] = 1'b0;
      endcase
    end
  end

  // First hit nearest the head, and the slots from there on that move up.
  always_comb begin
    logic seen;
    seen        = 1'b0;
    sel_id      = '0;
    sel_prio    = '0;
    sel_tag     = '0;
    for (int i = 0; i < DEPTH; i++) begin
      first_hit[i]   = match_r[i] && !seen;
      seen           = seen || match_r[i];
      at_or_after[i] = seen;
      if (first_hit[i]) begin
        sel_id   = sel_id   | slot_id_r[i];
        sel_prio = sel_prio | slot_prio_r[i];
        sel_tag  = sel_tag  | slot_tag_r[i];
      end
    end
  end

  // Next slot contents for an insert or a removal.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_id_nxt[i]   = slot_id_r[i];
      slot_prio_nxt[i] = slot_prio_r[i];
      slot_tag_nxt[i]  = slot_tag_r[i];
      if (cmd.commit_ins && !ge_r[i]) begin
        if (i == 0 || ge_r[(i == 0) ? 0 : i - 1]) begin
          slot_id_nxt[i]   = next_id_r;
          slot_prio_nxt[i] = req_prio_r;
          slot_tag_nxt[i]  = req_tag_r;
        end else begin
          slot_id_nxt[i]   = slot_id_r[(i == 0) ? 0 : i - 1];
          slot_prio_nxt[i] = slot_prio_r[(i == 0) ? 0 : i - 1];
          slot_tag_nxt[i]  = slot_tag_r[(i == 0) ? 0 : i - 1];
        end
      end else if (cmd.commit_rem && at_or_after[i] && (i + 1 < DEPTH)) begin
        slot_id_nxt[i]   = slot_id_r[(i + 1 < DEPTH) ? i + 1 : i];
        slot_prio_nxt[i] = slot_prio_r[(i + 1 < DEPTH) ? i + 1 : i];
        slot_tag_nxt[i]  = slot_tag_r[(i + 1 < DEPTH) ? i + 1 : i];
      end
    end
  end

  // Occupancy and id counter updates.
  always_comb begin
    count_nxt   = count_r;
    next_id_nxt = next_id_r;
    if (cmd.commit_ins) begin
      count_nxt   = count_r + CW'(1);
      next_id_nxt = (&next_id_r) ? spq_pkg::ID_FIRST : next_id_r + IdW'(1);
    end else if (cmd.commit_rem) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      next_id_r <= spq_pkg::ID_FIRST;
    end else begin
      count_r   <= count_nxt;
      next_id_r <= next_id_nxt;
    end
  end

  // Slot array, captured request, compare vectors and result fields.
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_id_r[i]   <= slot_id_nxt[i];
      slot_prio_r[i] <= slot_prio_nxt[i];
      slot_tag_r[i]  <= slot_tag_nxt[i];
    end
    if (cmd.load) begin
      req_prio_r   <= in_priority_req;
      req_tag_r    <= in_tag;
      req_target_r <= in_target_id;
    end
    if (cmd.compare) begin
      ge_r    <= ge_nxt;
      match_r <= match_nxt;
    end
    if (cmd.apply) begin
      res_occ_r <= OccW'(count_nxt);
      if (cmd.commit_ins) begin
        res_id_r   <= next_id_r;
        res_prio_r <= req_prio_r;
        res_tag_r  <= req_tag_r;
      end else if (cmd.commit_rem) begin
        res_id_r   <= sel_id;
        res_prio_r <= sel_prio;
        res_tag_r  <= sel_tag;
      end else begin
        res_id_r   <= '0;
        res_prio_r <= '0;
        res_tag_r  <= '0;
      end
    end
  end

  assign out_entry_id       = res_id_r;
  assign out_entry_priority = res_prio_r;
  assign out_entry_tag      = res_tag_r;
  assign out_occupancy      = res_occ_r;

  // The queue never holds more entries than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("occupancy exceeds capacity");

  // A removal unlinks exactly one slot.
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_rem |-> ($onehot(first_hit) && count_r != '0))
    else $error("removal without a single hit");

  // An insert is never committed into a full queue.
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_ins |-> !stat.full)
    else $error("insert committed while full");

endmodule

// ===== sv/sorted_priority_queue.sv =====
// Sorted priority queue: compare-and-shift register array, head in slot 0.
// A taken request goes through the compare state and the commit state; its result strobe is registered in commit.
// Each request uses a compare step followed by a shift step.
// busy is high only in the compare cycle; a new request is taken during the commit cycle.
// Each result is shown for one cycle with out_valid; the receiver cannot stall.
// Synchronous active-low reset empties the queue and sets the next id to 1.
module sorted_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [spq_pkg::MODE_W-1:0]          in_mode,
  input  logic signed [spq_pkg::PRIO_W-1:0]   in_priority_req,
  input  logic [spq_pkg::TAG_W-1:0]           in_tag,
  input  logic [spq_pkg::ID_W-1:0]            in_target_id,
  output logic                                out_valid,
  output logic [spq_pkg::STAT_W-1:0]          out_status,
  output logic [spq_pkg::ID_W-1:0]            out_entry_id,
  output logic signed [spq_pkg::PRIO_W-1:0]   out_entry_priority,
  output logic [spq_pkg::TAG_W-1:0]           out_entry_tag,
  output logic [spq_pkg::OCC_W-1:0]           out_occupancy
);

  spq_pkg::dp_cmd_t  cmd;
  spq_pkg::dp_stat_t stat;

  // Sequencing of compare and commit.
  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_mode    (in_mode),
    .stat       (stat),
    .busy       (busy),
    .cmd        (cmd),
    .out_valid  (out_valid),
    .out_status (out_status)
  );

  // Slot array and result fields.
  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_priority_req    (in_priority_req),
    .in_tag             (in_tag),
    .in_target_id       (in_target_id),
    .stat               (stat),
    .out_entry_id       (out_entry_id),
    .out_entry_priority (out_entry_priority),
    .out_entry_tag      (out_entry_tag),
    .out_occupancy      (out_occupancy)
  );

endmodule
